// ----- rtl/core/rrsg_pkg.sv -----
package rrsg_pkg;

    // Coordinate and derived widths
    localparam int CB    = 13;          // coordinate width
    localparam int RB    = CB - 1;      // radius width
    localparam int GW    = CB + 3;      // internal signed geometry width
    localparam int SQ_W  = 2 * RB;      // width of a squared radius
    localparam int ACC_W = 4 * CB;      // arc search accumulator width
    localparam int IDX_W = 3;           // configuration index width

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_TARGET_LEFT   = 3'd0;
    localparam logic [IDX_W-1:0] REG_TARGET_TOP    = 3'd1;
    localparam logic [IDX_W-1:0] REG_TARGET_RIGHT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_TARGET_BOTTOM = 3'd3;
    localparam logic [IDX_W-1:0] REG_CLIP_LEFT     = 3'd4;
    localparam logic [IDX_W-1:0] REG_CLIP_TOP      = 3'd5;
    localparam logic [IDX_W-1:0] REG_CLIP_RIGHT    = 3'd6;
    localparam logic [IDX_W-1:0] REG_CLIP_BOTTOM   = 3'd7;

    typedef struct packed {
        logic signed [CB-1:0] left;
        logic signed [CB-1:0] top;
        logic signed [CB-1:0] right;
        logic signed [CB-1:0] bottom;
    } rect_t;

    // Span control that rides along the arc search
    typedef struct packed {
        logic                 full;     // full clip width
        logic                 arc;      // arc line span
        logic                 flag_x;
        logic signed [GW-1:0] cx;
        logic signed [GW-1:0] dx;
    } span_ctl_t;

    // Geometry front end to arc search
    typedef struct packed {
        span_ctl_t         ctl;
        logic [RB-1:0]     rx;
        logic [SQ_W-1:0]   ry_sq;
        logic [ACC_W-1:0]  rhs;
    } arc_in_t;

    // One step of the arc search
    typedef struct packed {
        span_ctl_t         ctl;
        logic [RB-1:0]     rx;
        logic [SQ_W-1:0]   ry_sq;
        logic [ACC_W-1:0]  rhs;
        logic [ACC_W-1:0]  t;       // ry^2 * m^2
        logic [ACC_W-1:0]  p;       // ry^2 * m
        logic [CB-1:0]     m;
    } arc_st_t;

endpackage

// ----- rtl/core/rounded_rect_span_generator.sv -----
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------
// input    | in_valid / in_ready    | corner_radius, row
// output   | out_valid / out_ready  | span_present, span_start, span_end
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Fully pipelined: one transaction per cycle while the output is not stalled,
// through 9 geometry stages, CB arc search stages (one bit of the arc width
// each), one span stage and the output register. cfg_ready is always high.
// Reset clears valid bits and configuration registers (all zero).
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module rounded_rect_span_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rrsg_pkg::RB-1:0]        corner_radius,
    input  logic signed [rrsg_pkg::CB-1:0] row,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           span_present,
    output logic signed [rrsg_pkg::CB-1:0] span_start,
    output logic signed [rrsg_pkg::CB-1:0] span_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rrsg_pkg::IDX_W-1:0]     cfg_index,
    input  logic signed [rrsg_pkg::CB-1:0] cfg_data
);
    import rrsg_pkg::*;

    rect_t          target_reg, clip_reg;
    logic           en;
    logic           geom_valid, arc_valid;
    arc_in_t        geom_data;
    span_ctl_t      arc_ctl;
    logic [CB-1:0]  arc_m;

    logic           f_valid_reg, f_have_reg;
    logic signed [GW-1:0] fs_reg, fe_reg;
    logic signed [GW-1:0] cl_ext, cr_ext, s_clamp, e_clamp;
    logic           present_next;

    logic           out_valid_reg, present_reg;
    logic signed [CB-1:0] start_reg, end_reg;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            clip_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TARGET_LEFT:   target_reg.left   <= cfg_data;
                REG_TARGET_TOP:    target_reg.top    <= cfg_data;
                REG_TARGET_RIGHT:  target_reg.right  <= cfg_data;
                REG_TARGET_BOTTOM: target_reg.bottom <= cfg_data;
                REG_CLIP_LEFT:     clip_reg.left     <= cfg_data;
                REG_CLIP_TOP:      clip_reg.top      <= cfg_data;
                REG_CLIP_RIGHT:    clip_reg.right    <= cfg_data;
                REG_CLIP_BOTTOM:   clip_reg.bottom   <= cfg_data;
                default:           ;
            endcase
        end
    end

    rrsg_geom u_geom (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .corner_radius (corner_radius),
        .row           (row),
        .target        (target_reg),
        .clip          (clip_reg),
        .out_valid     (geom_valid),
        .out_data      (geom_data)
    );

    rrsg_arc u_arc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (geom_valid),
        .in_data   (geom_data),
        .out_valid (arc_valid),
        .out_ctl   (arc_ctl),
        .out_m     (arc_m)
    );

    // valid bits of the span and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg   <= arc_valid;
            out_valid_reg <= f_valid_reg;
        end
    end

    // raw span ends
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_have_reg <= arc_ctl.full || arc_ctl.arc;
            if (arc_ctl.full)
            begin
                fs_reg <= GW'(clip_reg.left);
                fe_reg <= GW'(clip_reg.right);
            end
            else
            begin
                fs_reg <= arc_ctl.cx - $signed(GW'(arc_m)) - arc_ctl.dx;
                fe_reg <= arc_ctl.cx + $signed(GW'(arc_m)) + arc_ctl.dx
                        + GW'(arc_ctl.flag_x);
            end
        end
    end

    // clamp into the clip columns
    always_comb
    begin
        cl_ext = GW'(clip_reg.left);
        cr_ext = GW'(clip_reg.right);
        if (fs_reg <= cl_ext)
            s_clamp = cl_ext;
        else if (fs_reg >= cr_ext)
            s_clamp = cr_ext;
        else
            s_clamp = fs_reg;
        if (fe_reg >= cr_ext)
            e_clamp = cr_ext;
        else if (fe_reg <= cl_ext)
            e_clamp = cl_ext;
        else
            e_clamp = fe_reg;
        present_next = f_have_reg && (s_clamp < e_clamp);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            present_reg <= present_next;
            start_reg   <= present_next ? CB'(s_clamp) : '0;
            end_reg     <= present_next ? CB'(e_clamp) : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign span_present = present_reg;
    assign span_start   = start_reg;
    assign span_end     = end_reg;

endmodule

// ----- rtl/core/rrsg_geom.sv -----
module rrsg_geom (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rrsg_pkg::RB-1:0]     corner_radius,
    input  logic signed [rrsg_pkg::CB-1:0] row,
    input  rrsg_pkg::rect_t             target,
    input  rrsg_pkg::rect_t             clip,
    output logic                        out_valid,
    output rrsg_pkg::arc_in_t           out_data
);
    import rrsg_pkg::*;

    localparam int NS = 9;

    logic [NS-1:0] v_reg;

    // stage 1
    logic [RB-1:0]        r1_reg;
    logic signed [CB-1:0] row1_reg;
    logic                 inclip1_reg;
    logic signed [GW-1:0] w1_reg, h1_reg;
    // stage 2
    logic signed [CB-1:0] row2_reg;
    logic                 inclip2_reg, zr2_reg, flag2_reg, flagx2_reg;
    logic [RB-1:0]        rx2_reg, ry2_reg;
    logic signed [GW-1:0] hw2_reg, hh2_reg;
    // stage 3
    logic signed [CB-1:0] row3_reg;
    logic                 inclip3_reg, zr3_reg, flag3_reg, flagx3_reg;
    logic [RB-1:0]        rx3_reg, ry3_reg;
    logic signed [GW-1:0] cx3_reg, cy3_reg, dx3_reg, dy3_reg;
    logic [SQ_W-1:0]      rxsq3_reg, rysq3_reg;
    // stage 4
    logic signed [CB-1:0] row4_reg;
    logic                 inclip4_reg, zr4_reg, flag4_reg, flagx4_reg;
    logic [RB-1:0]        rx4_reg, ry4_reg;
    logic signed [GW-1:0] cx4_reg, dx4_reg, top4_reg, bot4_reg;
    logic [SQ_W-1:0]      rxsq4_reg, rysq4_reg;
    logic [4*RB-1:0]      la4_reg;
    logic [3*RB-1:0]      lb4_reg;
    // stage 5
    logic                 inclip5_reg, full5_reg, flagx5_reg;
    logic [RB-1:0]        rx5_reg, ry5_reg;
    logic signed [GW-1:0] cx5_reg, dx5_reg, ku5_reg, kl5_reg;
    logic [SQ_W-1:0]      rxsq5_reg, rysq5_reg;
    logic [ACC_W-1:0]     lim5_reg;
    // stage 6..9
    span_ctl_t            ctl6_reg, ctl7_reg, ctl8_reg, ctl9_reg;
    logic [RB-1:0]        rx6_reg, rx7_reg, rx8_reg, rx9_reg;
    logic [SQ_W-1:0]      rysq6_reg, rysq7_reg, rysq8_reg, rysq9_reg;
    logic [SQ_W-1:0]      rxsq6_reg, rxsq7_reg;
    logic [ACC_W-1:0]     lim6_reg, lim7_reg, lim8_reg;
    logic [RB-1:0]        k6_reg;
    logic [SQ_W-1:0]      ksq7_reg;
    logic [4*RB-1:0]      sy8_reg;
    logic [ACC_W-1:0]     rhs9_reg;

    // combinational helpers
    logic signed [GW-1:0] hw_next, hh_next, two_r;
    logic                 fit_y, fit_x;
    logic [RB-1:0]        rx_next, ry_next;
    logic                 ku_ok, kl_ok;
    logic [RB-1:0]        k_next;
    logic [ACC_W-1:0]     sy_ext;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    assign out_valid = v_reg[NS-1];

    // stage 2 helpers: half sides (toward zero) and radius caps
    always_comb
    begin
        hw_next = (w1_reg + $signed(GW'(w1_reg < 0))) >>> 1;
        hh_next = (h1_reg + $signed(GW'(h1_reg < 0))) >>> 1;
        two_r   = $signed(GW'({r1_reg, 1'b0}));
        fit_y   = two_r <= h1_reg;
        fit_x   = two_r <= w1_reg;
        if (fit_y)
            ry_next = r1_reg;
        else if (h1_reg >= 0)
            ry_next = RB'(hh_next);
        else
            ry_next = '0;
        if (fit_x)
            rx_next = r1_reg;
        else if (w1_reg >= 0)
            rx_next = RB'(hw_next);
        else
            rx_next = '0;
    end

    // stage 6 helper: nearest arc line
    always_comb
    begin
        ku_ok = (ku5_reg >= 1) && (ku5_reg <= $signed(GW'(ry5_reg)));
        kl_ok = (kl5_reg >= 1) && (kl5_reg <= $signed(GW'(ry5_reg)));
        if (ku_ok && !(kl_ok && (kl5_reg < ku5_reg)))
            k_next = RB'(ku5_reg);
        else if (kl_ok)
            k_next = RB'(kl5_reg);
        else
            k_next = '0;
    end

    assign sy_ext = ACC_W'(sy8_reg);

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // 1: sides and clip rows
            r1_reg      <= corner_radius;
            row1_reg    <= row;
            inclip1_reg <= (row >= clip.top) && (row < clip.bottom);
            w1_reg      <= GW'(target.right) - GW'(target.left);
            h1_reg      <= GW'(target.bottom) - GW'(target.top);
            // 2: radii
            row2_reg    <= row1_reg;
            inclip2_reg <= inclip1_reg;
            zr2_reg     <= (r1_reg == '0);
            flag2_reg   <= ~h1_reg[0];
            flagx2_reg  <= w1_reg[0];
            rx2_reg     <= rx_next;
            ry2_reg     <= ry_next;
            hw2_reg     <= hw_next;
            hh2_reg     <= hh_next;
            // 3: centers, band offsets (zero for an inverted side), squares
            row3_reg    <= row2_reg;
            inclip3_reg <= inclip2_reg;
            zr3_reg     <= zr2_reg;
            flag3_reg   <= flag2_reg;
            flagx3_reg  <= flagx2_reg;
            rx3_reg     <= rx2_reg;
            ry3_reg     <= ry2_reg;
            cx3_reg     <= GW'(target.left) + hw2_reg;
            cy3_reg     <= GW'(target.top) + hh2_reg;
            dx3_reg     <= (hw2_reg < 0) ? '0 : hw2_reg - $signed(GW'(rx2_reg));
            dy3_reg     <= (hh2_reg < 0) ? '0 : hh2_reg - $signed(GW'(ry2_reg));
            rxsq3_reg   <= rx2_reg * rx2_reg;
            rysq3_reg   <= ry2_reg * ry2_reg;
            // 4: band rows, limit products
            row4_reg    <= row3_reg;
            inclip4_reg <= inclip3_reg;
            zr4_reg     <= zr3_reg;
            flag4_reg   <= flag3_reg;
            flagx4_reg  <= flagx3_reg;
            rx4_reg     <= rx3_reg;
            ry4_reg     <= ry3_reg;
            cx4_reg     <= cx3_reg;
            dx4_reg     <= dx3_reg;
            top4_reg    <= cy3_reg - dy3_reg;
            bot4_reg    <= cy3_reg + dy3_reg;
            rxsq4_reg   <= rxsq3_reg;
            rysq4_reg   <= rysq3_reg;
            la4_reg     <= rxsq3_reg * rysq3_reg;
            lb4_reg     <= rxsq3_reg * ry3_reg;
            // 5: band test, arc line offsets, limit
            inclip5_reg <= inclip4_reg;
            full5_reg   <= inclip4_reg && (zr4_reg ||
                           ((GW'(row4_reg) >= top4_reg) && (GW'(row4_reg) <= bot4_reg)));
            flagx5_reg  <= flagx4_reg;
            rx5_reg     <= rx4_reg;
            ry5_reg     <= ry4_reg;
            cx5_reg     <= cx4_reg;
            dx5_reg     <= dx4_reg;
            ku5_reg     <= top4_reg - GW'(row4_reg);
            kl5_reg     <= GW'(row4_reg) - bot4_reg + GW'(flag4_reg);
            rxsq5_reg   <= rxsq4_reg;
            rysq5_reg   <= rysq4_reg;
            lim5_reg    <= ACC_W'(la4_reg) + ACC_W'(lb4_reg >> 1);
            // 6: arc line select
            ctl6_reg.full   <= full5_reg;
            ctl6_reg.arc    <= inclip5_reg && !full5_reg && (ku_ok || kl_ok);
            ctl6_reg.flag_x <= flagx5_reg;
            ctl6_reg.cx     <= cx5_reg;
            ctl6_reg.dx     <= dx5_reg;
            rx6_reg     <= rx5_reg;
            rysq6_reg   <= rysq5_reg;
            rxsq6_reg   <= rxsq5_reg;
            lim6_reg    <= lim5_reg;
            k6_reg      <= k_next;
            // 7: k squared
            ctl7_reg    <= ctl6_reg;
            rx7_reg     <= rx6_reg;
            rysq7_reg   <= rysq6_reg;
            rxsq7_reg   <= rxsq6_reg;
            lim7_reg    <= lim6_reg;
            ksq7_reg    <= k6_reg * k6_reg;
            // 8: rx^2 k^2
            ctl8_reg    <= ctl7_reg;
            rx8_reg     <= rx7_reg;
            rysq8_reg   <= rysq7_reg;
            lim8_reg    <= lim7_reg;
            sy8_reg     <= rxsq7_reg * ksq7_reg;
            // 9: search bound; a negative bound yields width 0
            ctl9_reg    <= ctl8_reg;
            rx9_reg     <= rx8_reg;
            rysq9_reg   <= rysq8_reg;
            rhs9_reg    <= (sy_ext > lim8_reg) ? '0 : lim8_reg - sy_ext;
        end
    end

    assign out_data.ctl   = ctl9_reg;
    assign out_data.rx    = rx9_reg;
    assign out_data.ry_sq = rysq9_reg;
    assign out_data.rhs   = rhs9_reg;

endmodule

// ----- rtl/core/rrsg_arc.sv -----
module rrsg_arc (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  rrsg_pkg::arc_in_t    in_data,
    output logic                 out_valid,
    output rrsg_pkg::span_ctl_t  out_ctl,
    output logic [rrsg_pkg::CB-1:0] out_m
);
    import rrsg_pkg::*;

    // one register stage per bit of m, MSB first
    arc_st_t    st_in  [CB];
    arc_st_t    st_reg [CB];
    logic [CB-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[CB-2:0], in_valid};
        end
    end

    genvar i;
    generate
        for (i = 0; i < CB; i++)
        begin : g_step
            localparam int B = CB - 1 - i;
            arc_st_t       nxt;
            logic [CB-1:0] cand_m;
            logic [ACC_W-1:0] cand_t;
            logic          take;

            if (i == 0)
            begin : g_first
                assign st_in[i] = '{ctl: in_data.ctl, rx: in_data.rx,
                                    ry_sq: in_data.ry_sq, rhs: in_data.rhs,
                                    t: '0, p: '0, m: '0};
            end
            else
            begin : g_next
                assign st_in[i] = st_reg[i-1];
            end

            // try setting bit B: ry^2(m+2^B)^2 = t + p*2^(B+1) + ry^2*2^(2B)
            always_comb
            begin
                nxt    = st_in[i];
                cand_m = st_in[i].m | (CB'(1) << B);
                cand_t = st_in[i].t + (st_in[i].p << (B + 1))
                       + (ACC_W'(st_in[i].ry_sq) << (2 * B));
                take   = (cand_m <= CB'(st_in[i].rx)) && (cand_t <= st_in[i].rhs);
                if (take)
                begin
                    nxt.m = cand_m;
                    nxt.t = cand_t;
                    nxt.p = st_in[i].p + (ACC_W'(st_in[i].ry_sq) << B);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[i] <= nxt;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[CB-1];
    assign out_ctl   = st_reg[CB-1].ctl;
    assign out_m     = st_reg[CB-1].m;

endmodule
